/* rtl/core/tsc_pkg.sv */
`default_nettype none
package tsc_pkg;

  localparam int CNT_W        = 32;
  localparam int BIN_LEN_W    = 5;
  localparam int HIST_BINS_DF = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Characters with special meaning
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EXCL   = 8'h21;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_text;
  } tsc_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]     char_total;
    logic [CNT_W-1:0]     letter_total;
    logic [CNT_W-1:0]     space_total;
    logic [CNT_W-1:0]     punct_total;
    logic [CNT_W-1:0]     digit_total;
    logic [CNT_W-1:0]     word_total;
    logic [CNT_W-1:0]     sentence_total;
    logic [CNT_W-1:0]     line_total;
    logic [BIN_LEN_W-1:0] bin_length;
    logic [CNT_W-1:0]     bin_count;
    logic                 last_bin;
  } tsc_out_t;

  typedef enum logic [2:0] {
    S_RUN,   // taking text bytes
    S_FIN,   // settle lookahead byte, close open word
    S_RD,    // read histogram bin
    S_WAIT,  // bin data back, load result
    S_OUT    // result held until taken
  } tsc_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_pun(input logic [7:0] c);
    is_pun = (c >= 8'h21) && (c <= 8'h7E) && !is_letter(c) && !is_digit(c);
  endfunction

  function automatic logic is_mark(input logic [7:0] c);
    is_mark = (c == CH_PERIOD) || (c == CH_SEMI) || (c == CH_EXCL) || (c == CH_QUEST);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tsc_ram.sv */
`default_nettype none
module tsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                                        clk,
  input  wire                                        we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                            wdata,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/text_statistics_counter.sv */
// Drain: an accepted end-of-text item passes through S_FIN, then each of the HIST_BINS
//   results takes a histogram RAM read, a load and a hand-off (S_RD, S_WAIT, S_OUT).
// Throughput: one text byte per cycle in S_RUN; no bytes are taken during the drain, which
//   reads the bins one at a time through the single read port of the histogram RAM.
// Reset: rst_n synchronous, active low; clears counters (line count to one), lookahead and
//   the bin valid bits, so the histogram reads as zero without a clearing pass.
`default_nettype none
module text_statistics_counter #(
  parameter int HIST_BINS = tsc_pkg::HIST_BINS_DF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire tsc_pkg::tsc_in_t  in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output tsc_pkg::tsc_out_t      out_data
);
  import tsc_pkg::*;

  localparam int BIN_AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
  localparam int LEN_W  = $clog2(HIST_BINS + 1);
  localparam logic [BIN_AW-1:0] K_LAST  = BIN_AW'(HIST_BINS - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(HIST_BINS);

  tsc_state_t state_r, state_nxt;
  logic [BIN_AW-1:0] k_r, k_nxt;

  logic [CNT_W-1:0] chars_r, chars_nxt, letters_r, letters_nxt;
  logic [CNT_W-1:0] spaces_r, spaces_nxt, puncts_r, puncts_nxt;
  logic [CNT_W-1:0] digits_r, digits_nxt, words_r, words_nxt;
  logic [CNT_W-1:0] sents_r, sents_nxt, lines_r, lines_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       pend_byte_r, pend_byte_nxt, bef_byte_r, bef_byte_nxt;
  logic             pend_vld_r, pend_vld_nxt, bef_vld_r, bef_vld_nxt;

  // Histogram update stage and write forwarding
  logic              upd_vld_r, upd_vld_nxt;
  logic [BIN_AW-1:0] upd_addr_r, upd_addr_nxt;
  logic              fwd_vld_r;
  logic [BIN_AW-1:0] fwd_addr_r;
  logic [CNT_W-1:0]  fwd_data_r;
  logic [HIST_BINS-1:0] bin_vld_r, bin_vld_nxt;

  logic [BIN_AW-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_data;
  logic              wr_en;
  logic [BIN_AW-1:0] wr_addr;
  logic [CNT_W-1:0]  wr_data;
  logic [CNT_W-1:0]  upd_cur;
  logic [CNT_W-1:0]  drain_cur;

  tsc_out_t out_r, out_nxt;

  tsc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HIST_BINS)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Read-modify-write of a bin; a never-written bin reads as zero
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == upd_addr_r)) begin
      upd_cur = fwd_data_r;
    end else if (bin_vld_r[upd_addr_r]) begin
      upd_cur = rd_data;
    end else begin
      upd_cur = '0;
    end
    if (fwd_vld_r && (fwd_addr_r == k_r)) begin
      drain_cur = fwd_data_r;
    end else if (bin_vld_r[k_r]) begin
      drain_cur = rd_data;
    end else begin
      drain_cur = '0;
    end
    wr_en   = upd_vld_r;
    wr_addr = upd_addr_r;
    wr_data = sat_inc(upd_cur);
  end

  // Control, classification and counters
  always_comb begin
    logic              do_settle;
    logic              do_final;
    logic              next_ws;
    logic              sclose;
    logic              close;
    logic              drain_done;
    logic [LEN_W-1:0]  len_a;
    logic [LEN_W-1:0]  idx_full;
    logic [BIN_AW:0]   kp1;

    do_settle  = 1'b0;
    do_final   = 1'b0;
    next_ws    = 1'b0;
    sclose     = 1'b0;
    drain_done = 1'b0;
    kp1        = {1'b0, k_r} + (BIN_AW + 1)'(1);

    state_nxt     = state_r;
    k_nxt         = k_r;
    chars_nxt     = chars_r;
    letters_nxt   = letters_r;
    spaces_nxt    = spaces_r;
    puncts_nxt    = puncts_r;
    digits_nxt    = digits_r;
    words_nxt     = words_r;
    sents_nxt     = sents_r;
    lines_nxt     = lines_r;
    pend_byte_nxt = pend_byte_r;
    pend_vld_nxt  = pend_vld_r;
    bef_byte_nxt  = bef_byte_r;
    bef_vld_nxt   = bef_vld_r;
    upd_vld_nxt   = 1'b0;
    upd_addr_nxt  = upd_addr_r;
    bin_vld_nxt   = bin_vld_r;
    out_nxt       = out_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;

    if (wr_en) begin
      bin_vld_nxt[wr_addr] = 1'b1;
    end

    case (state_r)
      S_RUN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          do_settle = in_data.has_char && pend_vld_r;
          next_ws   = is_ws(in_data.ch);
          if (in_data.end_of_text) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        do_settle = pend_vld_r;
        do_final  = 1'b1;
        k_nxt     = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        out_nxt.char_total     = chars_r;
        out_nxt.letter_total   = letters_r;
        out_nxt.space_total    = spaces_r;
        out_nxt.punct_total    = puncts_r;
        out_nxt.digit_total    = digits_r;
        out_nxt.word_total     = words_r;
        out_nxt.sentence_total = sents_r;
        out_nxt.line_total     = lines_r;
        out_nxt.bin_length     = BIN_LEN_W'(kp1);
        out_nxt.bin_count      = drain_cur;
        out_nxt.last_bin       = (k_r == K_LAST);
        state_nxt              = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (k_r == K_LAST) begin
            drain_done = 1'b1;
            state_nxt  = S_RUN;
          end else begin
            k_nxt     = BIN_AW'(kp1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase

    // Settle the lookahead byte now that the byte after it is known
    len_a = len_r;
    if (do_settle) begin
      chars_nxt = sat_inc(chars_r);
      if (is_ws(pend_byte_r)) begin
        if (pend_byte_r == CH_NL) begin
          lines_nxt = sat_inc(lines_r);
        end else begin
          spaces_nxt = sat_inc(spaces_r);
        end
        sclose = 1'b1;
      end else if (is_pun(pend_byte_r)) begin
        puncts_nxt = sat_inc(puncts_r);
        if (bef_vld_r && !is_pun(bef_byte_r) && !next_ws) begin
          sclose = 1'b1;
        end
        if (is_mark(pend_byte_r)) begin
          sents_nxt = sat_inc(sents_r);
        end
      end else begin
        if (is_letter(pend_byte_r)) begin
          letters_nxt = sat_inc(letters_r);
        end else if (is_digit(pend_byte_r)) begin
          digits_nxt = sat_inc(digits_r);
        end
        if (len_a < LEN_MAX) begin
          len_a = len_a + LEN_W'(1);
        end
      end
      bef_byte_nxt = pend_byte_r;
      bef_vld_nxt  = 1'b1;
      pend_vld_nxt = 1'b0;
    end
    if ((state_r == S_RUN) && in_valid && in_data.has_char) begin
      pend_byte_nxt = in_data.ch;
      pend_vld_nxt  = 1'b1;
    end

    // Word close: count it and start the bin read
    close    = (sclose || do_final) && (len_a != '0);
    len_nxt  = (sclose || do_final) ? '0 : len_a;
    idx_full = len_a - LEN_W'(1);
    rd_addr  = idx_full[BIN_AW-1:0];
    if (close) begin
      words_nxt    = sat_inc(words_r);
      upd_vld_nxt  = 1'b1;
      upd_addr_nxt = idx_full[BIN_AW-1:0];
    end
    if (state_r == S_RD) begin
      rd_addr = k_r;
    end

    // Text done: back to the reset state
    if (drain_done) begin
      chars_nxt     = '0;
      letters_nxt   = '0;
      spaces_nxt    = '0;
      puncts_nxt    = '0;
      digits_nxt    = '0;
      words_nxt     = '0;
      sents_nxt     = '0;
      lines_nxt     = CNT_W'(1);
      len_nxt       = '0;
      pend_byte_nxt = '0;
      pend_vld_nxt  = 1'b0;
      bef_byte_nxt  = '0;
      bef_vld_nxt   = 1'b0;
      bin_vld_nxt   = '0;
    end
  end

  // Control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      k_r         <= '0;
      chars_r     <= '0;
      letters_r   <= '0;
      spaces_r    <= '0;
      puncts_r    <= '0;
      digits_r    <= '0;
      words_r     <= '0;
      sents_r     <= '0;
      lines_r     <= CNT_W'(1);
      len_r       <= '0;
      pend_byte_r <= '0;
      pend_vld_r  <= 1'b0;
      bef_byte_r  <= '0;
      bef_vld_r   <= 1'b0;
      upd_vld_r   <= 1'b0;
      fwd_vld_r   <= 1'b0;
      bin_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      chars_r     <= chars_nxt;
      letters_r   <= letters_nxt;
      spaces_r    <= spaces_nxt;
      puncts_r    <= puncts_nxt;
      digits_r    <= digits_nxt;
      words_r     <= words_nxt;
      sents_r     <= sents_nxt;
      lines_r     <= lines_nxt;
      len_r       <= len_nxt;
      pend_byte_r <= pend_byte_nxt;
      pend_vld_r  <= pend_vld_nxt;
      bef_byte_r  <= bef_byte_nxt;
      bef_vld_r   <= bef_vld_nxt;
      upd_vld_r   <= upd_vld_nxt;
      fwd_vld_r   <= wr_en;
      bin_vld_r   <= bin_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    upd_addr_r <= upd_addr_nxt;
    fwd_addr_r <= wr_addr;
    fwd_data_r <= wr_data;
    out_r      <= out_nxt;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

/* rtl/core/tsc_checker.sv */
`default_nettype none
module tsc_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_ready,
  input wire tsc_pkg::tsc_in_t  in_data,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire tsc_pkg::tsc_out_t out_data
);
  import tsc_pkg::*;

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No text bytes taken while results drain
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input open during drain");

  // End of text closes the input side
  a_eot_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.end_of_text |=> !in_ready)
    else $error("input open after end of text");

  // Last bin taken reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_bin |=> in_ready && !out_valid)
    else $error("input not reopened after last bin");

  // Line count never drops below one
  a_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.line_total != '0)
    else $error("line total is zero");

endmodule

bind text_statistics_counter tsc_checker u_tsc_checker (.*);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import tsc_pkg::*;

  localparam int NBINS      = HIST_BINS_DF;
  localparam int DRAIN_WAIT = 4 + 3 * NBINS + 8;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  tsc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tsc_out_t out_data;

  text_statistics_counter #(.HIST_BINS(NBINS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Stimulus and expectations
  tsc_in_t  pending_items[$];
  tsc_out_t expected_bins[$];
  int       items_queued   = 0;
  int       items_accepted = 0;
  int       texts_closed   = 0;
  int       results_seen   = 0;
  int       mismatches     = 0;
  int       cycle          = 0;
  logic     noisy;

  // Predicted text statistics
  logic [31:0] n_chars, n_letters, n_spaces, n_puncts, n_digits;
  logic [31:0] n_words, n_sentences, n_lines;
  logic [31:0] len_hist[NBINS];
  int          word_len;
  logic [7:0]  look_byte, prev_byte;
  bit          look_valid, prev_valid;

  // Clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Long quiet window with no idling on either side
  always @(posedge clk) begin
    cycle <= cycle + 1;
  end
  assign noisy = !(cycle >= 800 && cycle < 1600);

  // Byte classes, C locale
  function automatic bit ws_byte(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit letter_byte(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit punct_byte(input logic [7:0] c);
    return c >= 8'd33 && c <= 8'd126 && !letter_byte(c) && !digit_byte(c);
  endfunction

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  task automatic clear_stats();
    n_chars = '0; n_letters = '0; n_spaces = '0; n_puncts = '0;
    n_digits = '0; n_words = '0; n_sentences = '0;
    n_lines = 32'd1;
    word_len = 0;
    look_byte = '0; prev_byte = '0;
    look_valid = 0; prev_valid = 0;
    for (int k = 0; k < NBINS; k++) len_hist[k] = '0;
  endtask

  // Empty words leave no trace
  task automatic end_word();
    if (word_len > 0) begin
      n_words = bump(n_words);
      len_hist[word_len - 1] = bump(len_hist[word_len - 1]);
    end
    word_len = 0;
  endtask

  // Classify the lookahead byte once its successor is known
  task automatic settle_byte(input bit next_ws);
    logic [7:0] c;
    c = look_byte;
    n_chars = bump(n_chars);
    if (ws_byte(c)) begin
      if (c == CH_NL) n_lines = bump(n_lines);
      else n_spaces = bump(n_spaces);
      end_word();
    end else if (punct_byte(c)) begin
      n_puncts = bump(n_puncts);
      if (prev_valid && !punct_byte(prev_byte) && !next_ws) end_word();
      if (c == CH_PERIOD || c == CH_SEMI || c == CH_EXCL || c == CH_QUEST)
        n_sentences = bump(n_sentences);
    end else begin
      if (letter_byte(c)) n_letters = bump(n_letters);
      else if (digit_byte(c)) n_digits = bump(n_digits);
      if (word_len < NBINS) word_len++;
    end
    prev_byte = c;
    prev_valid = 1;
    look_valid = 0;
  endtask

  task automatic predict_item(input tsc_in_t it);
    tsc_out_t r;
    if (it.has_char) begin
      if (look_valid) settle_byte(ws_byte(it.ch));
      look_byte = it.ch;
      look_valid = 1;
    end
    if (it.end_of_text) begin
      if (look_valid) settle_byte(0);
      end_word();
      for (int k = 0; k < NBINS; k++) begin
        r.char_total     = n_chars;
        r.letter_total   = n_letters;
        r.space_total    = n_spaces;
        r.punct_total    = n_puncts;
        r.digit_total    = n_digits;
        r.word_total     = n_words;
        r.sentence_total = n_sentences;
        r.line_total     = n_lines;
        r.bin_length     = BIN_LEN_W'(k + 1);
        r.bin_count      = len_hist[k];
        r.last_bin       = (k == NBINS - 1);
        expected_bins.push_back(r);
      end
      clear_stats();
      texts_closed++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on result %0d, %s: got %0h, expected %0h",
             $realtime, results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input tsc_out_t got);
    tsc_out_t want;
    if (expected_bins.size() == 0) begin
      report_mismatch("result with none expected", 32'(got.bin_length), 32'd0);
    end else begin
      want = expected_bins.pop_front();
      if (got.char_total !== want.char_total)
        report_mismatch("char_total", got.char_total, want.char_total);
      if (got.letter_total !== want.letter_total)
        report_mismatch("letter_total", got.letter_total, want.letter_total);
      if (got.space_total !== want.space_total)
        report_mismatch("space_total", got.space_total, want.space_total);
      if (got.punct_total !== want.punct_total)
        report_mismatch("punct_total", got.punct_total, want.punct_total);
      if (got.digit_total !== want.digit_total)
        report_mismatch("digit_total", got.digit_total, want.digit_total);
      if (got.word_total !== want.word_total)
        report_mismatch("word_total", got.word_total, want.word_total);
      if (got.sentence_total !== want.sentence_total)
        report_mismatch("sentence_total", got.sentence_total, want.sentence_total);
      if (got.line_total !== want.line_total)
        report_mismatch("line_total", got.line_total, want.line_total);
      if (got.bin_length !== want.bin_length)
        report_mismatch("bin_length", 32'(got.bin_length), 32'(want.bin_length));
      if (got.bin_count !== want.bin_count)
        report_mismatch("bin_count", got.bin_count, want.bin_count);
      if (got.last_bin !== want.last_bin)
        report_mismatch("last_bin", 32'(got.last_bin), 32'(want.last_bin));
    end
    results_seen++;
  endtask

  // Driver: one item per handshake, random gaps only while valid is low
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_data);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && !(noisy && $urandom_range(99) < 26)) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      out_ready <= !(noisy && $urandom_range(99) < 26);
    end
  end

  task automatic push_item(input logic [7:0] c, input bit has, input bit fin);
    tsc_in_t it;
    it.ch = c;
    it.has_char = has;
    it.end_of_text = fin;
    pending_items.push_back(it);
    if (has || fin) items_queued++;
  endtask

  function automatic logic [7:0] pick_punct();
    logic [7:0] c;
    case ($urandom_range(3))
      0: c = CH_PERIOD;
      1: c = CH_QUEST;
      default: begin
        c = 8'($urandom_range(33, 126));
        while (!punct_byte(c)) c = 8'($urandom_range(33, 126));
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_word_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) begin
      return $urandom_range(1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
    end else if (roll < 95) begin
      return 8'($urandom_range("0", "9"));
    end
    // unclassified bytes still lengthen the word
    return $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(14, 31));
  endfunction

  // Mostly word-shaped text with random separators and some noise
  task automatic build_text();
    int tokens;
    int len;
    tokens = $urandom_range(1, 12);
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          len = ($urandom_range(8) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 7);
          for (int i = 0; i < len; i++) push_item(pick_word_byte(), 1, 0);
        end
        4: push_item($urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13)), 1, 0);
        5: push_item(CH_NL, 1, 0);
        6: begin
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++) push_item(pick_punct(), 1, 0);
        end
        7: push_item(8'($urandom_range(255)), 0, 0);
        8: push_item(8'($urandom_range(255)), 1, 0);
        default: begin
          push_item(pick_punct(), 1, 0);
          push_item(CH_SPACE, 1, 0);
        end
      endcase
    end
    if ($urandom_range(1)) push_item(8'($urandom_range(255)), 1, 1);
    else push_item(8'($urandom_range(255)), 0, 1);
  endtask

  // Main sequence
  initial begin
    int spins;
    clear_stats();

    // empty text
    push_item(8'h00, 0, 1);
    // leading punct, punct between letters, punct before space, runs of marks
    push_item(",", 1, 0);
    push_item("a", 1, 0);
    push_item(CH_PERIOD, 1, 0);
    push_item("b", 1, 0);
    push_item(CH_SEMI, 1, 0);
    push_item(CH_SPACE, 1, 0);
    push_item(CH_EXCL, 1, 0);
    push_item(CH_QUEST, 1, 0);
    push_item(CH_NL, 1, 0);
    // byte extremes and unclassified bytes
    push_item(8'h00, 1, 0);
    push_item(8'hFF, 1, 0);
    push_item(8'h80, 1, 0);
    push_item(8'h7F, 1, 0);
    push_item("9", 1, 0);
    push_item(CH_TAB, 1, 0);
    push_item(8'hA5, 0, 0);
    push_item("Z", 1, 1);
    // punct run inside a word, then end with no byte
    push_item("x", 1, 0);
    push_item("-", 1, 0);
    push_item("-", 1, 0);
    push_item("y", 1, 0);
    push_item(CH_CR, 1, 0);
    push_item(8'hFF, 0, 1);

    while (items_queued < 310) build_text();

    while (!rst_n || pending_items.size() > 0 || in_valid) @(posedge clk);
    spins = 0;
    while (expected_bins.size() > 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_bins.size() > 0)
      report_mismatch("results never delivered", expected_bins.size(), 0);

    $display("Ran %0d texts over %0d input items; %0d histogram results checked",
             texts_closed, items_accepted, results_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding", expected_bins.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
